/* sv/psu_pkg.sv */
// ----------------------------------------------------------------------------
// psu_pkg
// shared types, constants and the paeth predictor for the scanline unfilter
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_LINE_BYTES = 8192;
  localparam int COL_W          = $clog2(MAX_LINE_BYTES);
  localparam int LEN_W          = $clog2(MAX_LINE_BYTES + 1);
  localparam int WIDTH_W        = 12;
  localparam int HEIGHT_W       = 16;
  localparam int BPP_W          = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    FLT_NONE  = 3'd0,
    FLT_SUB   = 3'd1,
    FLT_UP    = 3'd2,
    FLT_AVG   = 3'd3,
    FLT_PAETH = 3'd4,
    FLT_BAD   = 3'd5
  } filter_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_BPP    = 2'd2
  } cfg_idx_t;

  // one data byte on its way from front to back
  typedef struct packed {
    logic [7:0]       data;
    filter_t          filt;
    logic [COL_W-1:0] col;
    logic             first;
    logic             row_zero;
    logic             eol;
    logic             eoi;
  } item_t;

  // paeth predictor, ties go to a, then b
  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] da;
    logic signed [9:0] db;
    logic signed [9:0] dc;
    logic [9:0]        pa;
    logic [9:0]        pb;
    logic [9:0]        pc;
    logic [7:0]        res;
    da = $signed({2'b00, b}) - $signed({2'b00, c});
    db = $signed({2'b00, a}) - $signed({2'b00, c});
    dc = da + db;
    pa = da[9] ? 10'(-da) : 10'(da);
    pb = db[9] ? 10'(-db) : 10'(db);
    pc = dc[9] ? 10'(-dc) : 10'(dc);
    if (pa <= pb && pa <= pc) begin
      res = a;
    end else if (pb <= pc) begin
      res = b;
    end else begin
      res = c;
    end
    return res;
  endfunction

endpackage

/* sv/png_scanline_unfilter.sv */
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// png filter reconstruction (none, sub, up, average, paeth), while not stalled one byte per clock
// ----------------------------------------------------------------------------
// usage
//   in_*  : inflated scanline bytes, one request per byte; the first byte of
//           each line is the filter type and yields no output
//   out_* : one reconstructed pixel byte per data byte, with end of line,
//           end of image and bad filter flags
//   cfg_* : width, height and bytes per pixel; cfg_ready is always high, write
//           only while idle; a write to index 0 to 2 restarts the image at row 0
// path    : an accepted data byte passes the queue entry, the line memory read
//           stage and the output register, in that order, before out_valid rises
// throughput : 1 byte per cycle sustained while out_stall is low; set by the
//           single line memory port pair (one read and one write per cycle)
// reset   : synchronous, active low; registers return to width 1, height 1,
//           3 bytes per pixel, expecting a filter byte; line memory is not
//           cleared, the first row reads the line above as zero
// stall   : out_stall freezes the output register and the back stage; the
//           4 entry queue then fills and in_stall rises when it is full
// ----------------------------------------------------------------------------
module png_scanline_unfilter (
  input  logic                            clk,
  input  logic                            rst_n,
  // input byte channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_stream_byte,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_pixel_byte,
  output logic                            out_last_of_line,
  output logic                            out_last_of_image,
  output logic                            out_bad_filter,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic           q_full;
  logic           push;
  psu_pkg::item_t push_item;
  logic           pix4;
  logic           pop;
  logic           q_valid;
  psu_pkg::item_t q_item;

  // config writes never wait
  assign cfg_ready = 1'b1;

  // front: counts columns and rows, tags each data byte with its context
  psu_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stream_byte (in_stream_byte),
    .in_stall       (in_stall),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item),
    .pix4           (pix4)
  );

  // decoupling queue
  psu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // back: line memory, predictor and output register
  psu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .pix4              (pix4),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_byte    (out_pixel_byte),
    .out_last_of_line  (out_last_of_line),
    .out_last_of_image (out_last_of_image),
    .out_bad_filter    (out_bad_filter)
  );

endmodule

/* sv/psu_front.sv */
// ----------------------------------------------------------------------------
// psu_front
// config registers, line and row tracking, classifies filter and data bytes
// ----------------------------------------------------------------------------
module psu_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [7:0]                      in_stream_byte,
  output logic                            in_stall,
  input  logic                            cfg_valid,
  input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            q_full,
  output logic                            push,
  output psu_pkg::item_t                  push_item,
  output logic                            pix4
);

  logic [psu_pkg::WIDTH_W-1:0]  width_r, width_nxt;
  logic [psu_pkg::HEIGHT_W-1:0] height_r, height_nxt;
  logic [psu_pkg::BPP_W-1:0]    bpp_r, bpp_nxt;
  logic [psu_pkg::COL_W-1:0]    col_r, col_nxt;
  logic [psu_pkg::HEIGHT_W-1:0] row_r, row_nxt;
  psu_pkg::filter_t             filt_r, filt_nxt;
  logic                         expect_r, expect_nxt;

  logic                         accept;
  logic [psu_pkg::WIDTH_W-1:0]  w_eff;
  logic [psu_pkg::LEN_W-1:0]    w_ext;
  logic [psu_pkg::LEN_W-1:0]    len_raw;
  logic [psu_pkg::LEN_W-1:0]    len;
  logic [psu_pkg::LEN_W-1:0]    col_inc;
  logic [psu_pkg::HEIGHT_W-1:0] h_eff;
  logic [psu_pkg::HEIGHT_W:0]   row_inc;
  logic                         eol;
  logic                         eoi;
  psu_pkg::filter_t             filt_in;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pix4     = (bpp_r != psu_pkg::BPP_W'(3));

  always_comb begin
    if (width_r == '0) begin
      w_eff = psu_pkg::WIDTH_W'(1);
    end else if (width_r > psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH)) begin
      w_eff = psu_pkg::WIDTH_W'(psu_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    w_ext   = psu_pkg::LEN_W'(w_eff);
    len_raw = pix4 ? (w_ext << 2) : (w_ext + (w_ext << 1));
    len     = (len_raw > psu_pkg::LEN_W'(psu_pkg::MAX_LINE_BYTES)) ?
              psu_pkg::LEN_W'(psu_pkg::MAX_LINE_BYTES) : len_raw;
    col_inc = psu_pkg::LEN_W'(col_r) + psu_pkg::LEN_W'(1);
    eol     = (col_inc >= len);
    h_eff   = (height_r == '0) ? psu_pkg::HEIGHT_W'(1) : height_r;
    row_inc = {1'b0, row_r} + (psu_pkg::HEIGHT_W+1)'(1);
    eoi     = eol && (row_inc >= {1'b0, h_eff});
    filt_in = (in_stream_byte > 8'd4) ? psu_pkg::FLT_BAD :
              psu_pkg::filter_t'(in_stream_byte[2:0]);
  end

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    bpp_nxt    = bpp_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    filt_nxt   = filt_r;
    expect_nxt = expect_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        psu_pkg::CFG_WIDTH:  width_nxt  = cfg_data[psu_pkg::WIDTH_W-1:0];
        psu_pkg::CFG_HEIGHT: height_nxt = cfg_data[psu_pkg::HEIGHT_W-1:0];
        psu_pkg::CFG_BPP:    bpp_nxt    = cfg_data[psu_pkg::BPP_W-1:0];
        default: ;
      endcase
      if (cfg_index == psu_pkg::CFG_WIDTH || cfg_index == psu_pkg::CFG_HEIGHT ||
          cfg_index == psu_pkg::CFG_BPP) begin
        col_nxt    = '0;
        row_nxt    = '0;
        filt_nxt   = psu_pkg::FLT_NONE;
        expect_nxt = 1'b1;
      end
    end else if (accept) begin
      if (expect_r) begin
        filt_nxt   = filt_in;
        expect_nxt = 1'b0;
        col_nxt    = '0;
      end else if (eol) begin
        expect_nxt = 1'b1;
        col_nxt    = '0;
        row_nxt    = eoi ? '0 : row_inc[psu_pkg::HEIGHT_W-1:0];
      end else begin
        col_nxt = col_inc[psu_pkg::COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= psu_pkg::WIDTH_W'(1);
      height_r <= psu_pkg::HEIGHT_W'(1);
      bpp_r    <= psu_pkg::BPP_W'(3);
      col_r    <= '0;
      row_r    <= '0;
      filt_r   <= psu_pkg::FLT_NONE;
      expect_r <= 1'b1;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      bpp_r    <= bpp_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      filt_r   <= filt_nxt;
      expect_r <= expect_nxt;
    end
  end

  assign push = accept && !expect_r;

  always_comb begin
    push_item.data     = in_stream_byte;
    push_item.filt     = filt_r;
    push_item.col      = col_r;
    push_item.first    = (col_r == '0);
    push_item.row_zero = (row_r == '0);
    push_item.eol      = eol;
    push_item.eoi      = eoi;
  end

endmodule

/* sv/psu_queue.sv */
// ----------------------------------------------------------------------------
// psu_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module psu_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psu_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output psu_pkg::item_t q_item
);

  psu_pkg::item_t              mem_r [psu_pkg::QUEUE_DEPTH];
  logic [psu_pkg::QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [psu_pkg::QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [psu_pkg::QPTR_W:0]    count_r, count_nxt;
  logic                        do_pop;

  assign full    = (count_r == (psu_pkg::QPTR_W+1)'(psu_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + psu_pkg::QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + psu_pkg::QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + (psu_pkg::QPTR_W+1)'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - (psu_pkg::QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* sv/psu_back.sv */
// ----------------------------------------------------------------------------
// psu_back
// line memory read, reconstruction and output register
// ----------------------------------------------------------------------------
module psu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  psu_pkg::item_t q_item,
  output logic           pop,
  input  logic           pix4,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_pixel_byte,
  output logic           out_last_of_line,
  output logic           out_last_of_image,
  output logic           out_bad_filter
);

  logic [7:0]     line_mem [psu_pkg::MAX_LINE_BYTES];
  logic [7:0]     b_mem_r;
  psu_pkg::item_t s1_r;
  logic           s1_valid_r, s1_valid_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    left_r, left_nxt;
  logic [31:0]    upleft_r, upleft_nxt;
  logic [7:0]     pix_r;
  logic           eol_r;
  logic           eoi_r;
  logic           bad_r;

  logic           adv;
  logic           s1_ready;
  logic           wr_en;
  logic [31:0]    left_v;
  logic [31:0]    upleft_v;
  logic [7:0]     a;
  logic [7:0]     b;
  logic [7:0]     c;
  logic [8:0]     ab_sum;
  logic [7:0]     pred;
  logic [7:0]     r;

  assign adv      = !out_valid_r || !out_stall;
  assign s1_ready = !s1_valid_r || adv;
  assign pop      = q_valid && s1_ready;
  assign wr_en    = adv && s1_valid_r;

  always_comb begin
    left_v   = s1_r.first ? '0 : left_r;
    upleft_v = s1_r.first ? '0 : upleft_r;
    a        = pix4 ? left_v[31:24] : left_v[23:16];
    c        = pix4 ? upleft_v[31:24] : upleft_v[23:16];
    b        = s1_r.row_zero ? 8'd0 : b_mem_r;
    ab_sum   = {1'b0, a} + {1'b0, b};
    case (s1_r.filt)
      psu_pkg::FLT_SUB:   pred = a;
      psu_pkg::FLT_UP:    pred = b;
      psu_pkg::FLT_AVG:   pred = ab_sum[8:1];
      psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(a, b, c);
      default:            pred = 8'd0;
    endcase
    r          = s1_r.data + pred;
    left_nxt   = wr_en ? {left_v[23:0], r} : left_r;
    upleft_nxt = wr_en ? {upleft_v[23:0], b} : upleft_r;
  end

  always_comb begin
    if (pop) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = adv ? s1_valid_r : out_valid_r;
  end

  // line memory: read for the popped item, write back the finished byte
  always_ff @(posedge clk) begin
    if (pop) begin
      b_mem_r <= line_mem[q_item.col];
    end
    if (wr_en) begin
      line_mem[s1_r.col] <= r;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_r <= q_item;
    end
    if (wr_en) begin
      pix_r <= r;
      eol_r <= s1_r.eol;
      eoi_r <= s1_r.eoi;
      bad_r <= (s1_r.filt == psu_pkg::FLT_BAD);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= '0;
      upleft_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
      upleft_r    <= upleft_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_byte    = pix_r;
  assign out_last_of_line  = eol_r;
  assign out_last_of_image = eoi_r;
  assign out_bad_filter    = bad_r;

endmodule

/* sv/psu_checker.sv */
// ----------------------------------------------------------------------------
// psu_checker
// port level checks for the scanline unfilter, bound to the top level
// ----------------------------------------------------------------------------
module psu_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [7:0]                      out_pixel_byte,
  input logic                            out_last_of_line,
  input logic                            out_last_of_image,
  input logic                            out_bad_filter
);

  // end of image is always also end of line
  a_eoi_eol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_of_image ? out_last_of_line : 1'b1))
    else $error("end of image without end of line");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pixel_byte) &&
      $stable(out_last_of_line) && $stable(out_last_of_image) &&
      $stable(out_bad_filter))
    else $error("stalled result changed");

  // reset empties the output side
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // reset empties the queue, so input is taken right away
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

endmodule

bind png_scanline_unfilter psu_checker u_psu_checker (.*);
